// ===== hdl/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg - shared types and constants of the depth-first maze carver
// Field widths, command and register codes, direction codes and the
// direction shuffle that seeds each new stack frame.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

  // Field widths of the channel words
  localparam int FUNC_W    = 1;
  localparam int RAND_W    = 8;
  localparam int CELL_W    = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 7;
  localparam int ORDER_W   = 8;
  localparam int NEXT_W    = 3;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_STEP    = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAZE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAZE_HEIGHT = 1'b1;

  // Register reset value and lower clamp of the grid size
  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;
  localparam logic [CFG_W-1:0] SIZE_MIN   = 7'd3;

  // Direction codes
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // Shuffle {up, down, left, right}: swap slot i with the slot drawn
  // from bits 2i+1:2i. Slot 0 lands in bits 1:0 of the result.
  function automatic logic [ORDER_W-1:0] shuffle_order(input logic [RAND_W-1:0] r);
    logic [1:0] d [4];
    logic [1:0] t;
    logic [1:0] j;
    d[0] = DIR_UP;
    d[1] = DIR_DOWN;
    d[2] = DIR_LEFT;
    d[3] = DIR_RIGHT;
    for (int i = 0; i < 4; i++) begin
      j    = r[2*i +: 2];
      t    = d[i];
      d[i] = d[j];
      d[j] = t;
    end
    return {d[3], d[2], d[1], d[0]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dmc_channels.sv =====
// ----------------------------------------------------------------------------
// dmc_channels - valid/ready channels of the maze carver
// Command channel, result channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmc_cmd_if;
  import dmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [RAND_W-1:0] rand_bits;

  modport source (output valid, output func, output rand_bits, input ready);
  modport sink   (input valid, input func, input rand_bits, output ready);
endinterface

interface dmc_res_if;
  import dmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_x;
  logic [CELL_W-1:0] cell_y;
  logic              finished;

  modport source (output valid, output cell_x, output cell_y, output finished,
                  input ready);
  modport sink   (input valid, input cell_x, input cell_y, input finished,
                  output ready);
endinterface

interface dmc_cfg_if;
  import dmc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/dfs_maze_carver.sv =====
// ----------------------------------------------------------------------------
// dfs_maze_carver - randomized depth-first maze carver
// Walks a grid of open/blocked cells with an explicit stack of frames and
// carves at most one new cell per step command. Grid bits and stacked frames sit in
// two single-port-read synchronous memories; the top frame is held in flops.
//
//   channel  dir  word                         handshake
//   cfg      in   index, data                  valid/ready, ready always high
//   cmd      in   func, rand_bits              valid/ready, ready when idle
//   res      out  cell_x, cell_y, finished     valid/ready, output register
//
// Restart: sweeps the whole MAX_WIDTH*MAX_HEIGHT grid memory, then reports cell (1,1).
// Step: for each direction tried, reads the grid (center and four neighbours
// through one read port) when the candidate is inside the border; a pop
// refills the top frame with a frame memory read; then the word is handed
// to the result register and the sequencer returns to idle.
// Reset clears the stack; the grid is swept by the next restart. A command
// is taken while an earlier result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_maze_carver #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire        clk,
  input  wire        rst,
  dmc_cfg_if.sink    cfg,
  dmc_cmd_if.sink    cmd,
  dmc_res_if.source  res
);
  import dmc_pkg::*;

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int CAW    = $clog2(CELLS);
  localparam int DW     = $clog2(CELLS + 1);
  localparam logic [CAW-1:0] ORIGIN_ADDR = CAW'(MAX_WIDTH + 1);
  localparam logic [CAW-1:0] LAST_ADDR   = CAW'(CELLS - 1);
  localparam logic [DW-1:0]  STACK_FULL  = DW'(CELLS);

  typedef struct packed {
    logic [XW-1:0]      x;
    logic [YW-1:0]      y;
    logic [ORDER_W-1:0] order;
    logic [NEXT_W-1:0]  next;
  } frame_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_TRY,
    S_CHECK,
    S_POP,
    S_DONE
  } state_t;

  function automatic logic [CAW-1:0] addr_of(input logic [XW-1:0] x,
                                             input logic [YW-1:0] y);
    return CAW'(y) * CAW'(MAX_WIDTH) + CAW'(x);
  endfunction

  // Control and payload registers
  state_t            state;
  logic [CFG_W-1:0]  maze_width;
  logic [CFG_W-1:0]  maze_height;
  logic [CAW-1:0]    clr_addr;
  logic [RAND_W-1:0] rnd;
  logic [DW-1:0]     depth;
  frame_t            top;
  logic [XW-1:0]     cand_x;
  logic [YW-1:0]     cand_y;
  logic [2:0]        ck;
  logic              nbr_seen;
  logic [XW-1:0]     pend_x;
  logic [YW-1:0]     pend_y;
  logic              pend_fin;
  logic              out_valid;
  logic [CELL_W-1:0] out_x;
  logic [CELL_W-1:0] out_y;
  logic              out_fin;

  // Memories
  logic              cell_mem [CELLS];
  logic              cw_en;
  logic [CAW-1:0]    cw_addr;
  logic              cw_data;
  logic              cr_en;
  logic [CAW-1:0]    cr_addr;
  logic              cr_data;
  frame_t            frame_mem [CELLS];
  logic              fw_en;
  logic [CAW-1:0]    fw_addr;
  logic              fr_en;
  logic [CAW-1:0]    fr_addr;
  frame_t            fr_data;

  // Combinational helpers
  logic [WW-1:0]     eff_w;
  logic [HW-1:0]     eff_h;
  logic [WW-1:0]     w_lim;
  logic [HW-1:0]     h_lim;
  logic [1:0]        dir;
  logic [XW-1:0]     nx;
  logic [YW-1:0]     ny;
  logic              in_bounds;
  logic [XW-1:0]     rd_x;
  logic [YW-1:0]     rd_y;
  logic              chk_fail;
  logic              chk_ok;
  logic [DW-1:0]     depth_m1;
  logic [DW-1:0]     depth_m2;
  logic              out_free;

  // Clamp the grid size to [3, MAX]
  always_comb begin
    if (maze_width < SIZE_MIN) begin
      eff_w = WW'(SIZE_MIN);
    end else if (32'(maze_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(maze_width);
    end
    if (maze_height < SIZE_MIN) begin
      eff_h = HW'(SIZE_MIN);
    end else if (32'(maze_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(maze_height);
    end
    w_lim = eff_w - WW'(1);
    h_lim = eff_h - HW'(1);
  end

  // Next candidate from the top frame's current direction
  always_comb begin
    dir = top.order[{top.next[1:0], 1'b0} +: 2];
    nx  = top.x;
    ny  = top.y;
    unique case (dir)
      DIR_UP:    ny = top.y - YW'(1);
      DIR_DOWN:  ny = top.y + YW'(1);
      DIR_LEFT:  nx = top.x - XW'(1);
      DIR_RIGHT: nx = top.x + XW'(1);
      default:   nx = top.x;
    endcase
    in_bounds = (nx != '0) && (ny != '0) && (WW'(nx) < w_lim) && (HW'(ny) < h_lim);
  end

  // Grid read address: center, down, up, right, left
  always_comb begin
    rd_x = cand_x;
    rd_y = cand_y;
    unique case (ck)
      3'd1:    rd_y = cand_y + YW'(1);
      3'd2:    rd_y = cand_y - YW'(1);
      3'd3:    rd_x = cand_x + XW'(1);
      3'd4:    rd_x = cand_x - XW'(1);
      default: rd_x = cand_x;
    endcase
    cr_addr = addr_of(rd_x, rd_y);
    cr_en   = (state == S_CHECK) && (ck <= 3'd4);
  end

  // Judge the word returned for the previous read
  assign chk_fail = (state == S_CHECK) && (ck != 3'd0) && cr_data &&
                    ((ck == 3'd1) || nbr_seen);
  assign chk_ok   = (state == S_CHECK) && (ck == 3'd5) && !chk_fail;

  assign depth_m1 = depth - DW'(1);
  assign depth_m2 = depth - DW'(2);

  // Grid writes: sweep on restart, set on carve
  always_comb begin
    cw_en   = (state == S_CLEAR) || chk_ok;
    cw_addr = (state == S_CLEAR) ? clr_addr : addr_of(cand_x, cand_y);
    cw_data = (state == S_CLEAR) ? (clr_addr == ORIGIN_ADDR) : 1'b1;
  end

  // Frame stack: spill top on push, refill top on pop
  always_comb begin
    fw_en   = chk_ok && (depth != STACK_FULL);
    fw_addr = depth_m1[CAW-1:0];
    fr_en   = (state == S_TRY) && (depth != '0) && top.next[2] && (depth != DW'(1));
    fr_addr = depth_m2[CAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cw_en) begin
      cell_mem[cw_addr] <= cw_data;
    end
    if (cr_en) begin
      cr_data <= cell_mem[cr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fw_en) begin
      frame_mem[fw_addr] <= top;
    end
    if (fr_en) begin
      fr_data <= frame_mem[fr_addr];
    end
  end

  // Size registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      maze_width  <= SIZE_RESET;
      maze_height <= SIZE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MAZE_WIDTH:  maze_width  <= cfg.data;
        REG_MAZE_HEIGHT: maze_height <= cfg.data;
        default:         maze_width  <= maze_width;
      endcase
    end
  end

  assign out_free  = !out_valid || res.ready;
  assign cmd.ready = (state == S_IDLE);

  // Walk sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop a taken word unless a waiting result reloads the register
      if (out_valid && res.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            rnd      <= cmd.rand_bits;
            clr_addr <= '0;
            if (cmd.func == FUNC_RESTART) begin
              depth <= '0;
              state <= S_CLEAR;
            end else begin
              state <= S_TRY;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + CAW'(1);
          if (clr_addr == LAST_ADDR) begin
            top.x     <= XW'(1);
            top.y     <= YW'(1);
            top.order <= shuffle_order(rnd);
            top.next  <= '0;
            depth     <= DW'(1);
            pend_x    <= XW'(1);
            pend_y    <= YW'(1);
            pend_fin  <= 1'b0;
            state     <= S_DONE;
          end
        end
        S_TRY: begin
          if (depth == '0) begin
            pend_x   <= '0;
            pend_y   <= '0;
            pend_fin <= 1'b1;
            state    <= S_DONE;
          end else if (top.next[2]) begin
            // Drop an exhausted frame
            depth <= depth_m1;
            if (depth != DW'(1)) begin
              state <= S_POP;
            end
          end else begin
            top.next <= top.next + NEXT_W'(1);
            cand_x   <= nx;
            cand_y   <= ny;
            ck       <= '0;
            nbr_seen <= 1'b0;
            if (in_bounds) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          ck <= ck + 3'd1;
          if ((ck != 3'd1) && (ck != 3'd0) && cr_data) begin
            nbr_seen <= 1'b1;
          end
          if (chk_fail) begin
            state <= S_TRY;
          end else if (chk_ok) begin
            // Carve the new cell and push it unless the stack is full
            if (depth != STACK_FULL) begin
              top.x     <= cand_x;
              top.y     <= cand_y;
              top.order <= shuffle_order(rnd);
              top.next  <= '0;
              depth     <= depth + DW'(1);
            end
            pend_x   <= cand_x;
            pend_y   <= cand_y;
            pend_fin <= 1'b0;
            state    <= S_DONE;
          end
        end
        S_POP: begin
          top   <= fr_data;
          state <= S_TRY;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_x     <= CELL_W'(pend_x);
            out_y     <= CELL_W'(pend_y);
            out_fin   <= pend_fin;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid    = out_valid;
  assign res.cell_x   = out_x;
  assign res.cell_y   = out_y;
  assign res.finished = out_fin;

  // Stack depth never passes the frame memory
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= STACK_FULL)
    else $error("stack depth beyond frame memory");

  // A taken command always leaves idle
  a_cmd_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> (state != S_IDLE))
    else $error("command taken but sequencer stayed idle");

  // Grid checks never look at a candidate on the top or left border
  a_cand_interior: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> ((cand_x != '0) && (cand_y != '0)))
    else $error("grid check on a border candidate");

  // A finished result only with an empty stack
  a_fin_empty: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && pend_fin) |-> (depth == '0))
    else $error("finished reported with frames left");

  // A frame refill only follows a pop that left frames
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> (depth != '0))
    else $error("frame refill with an empty stack");

endmodule

`default_nettype wire
